FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, masked while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tlpq_pkg.sv
package tlpq_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int NUM_LEVELS  = 3;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int Q_W   = $clog2(NUM_LEVELS);

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_EMPTY    = 2'd2;
    localparam status_t ST_BADLEVEL = 2'd3;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic item_load;
        logic exec;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_valid;
    } dp_stat_t;

    // Sign-extend or truncate a stored word to the 32-bit output field.
    function automatic logic [31:0] to_out32(word_t w);
        logic signed [DATA_WIDTH-1:0] sw;
        sw = $signed(w);
        return 32'(sw);
    endfunction

endpackage

FILE: sv/three_level_priority_queue_unit.sv
// Channel   Direction  Transaction
// s_*       in         one enqueue or dequeue request
// m_*       out        one result (status, word, level) per request
//
// Each request passes through accept, queue update with store read, and result load.
// The sequence is set by the controller around the registered store read.
// A new request is taken while the previous result still waits on m_*.
// A stalled m_tready holds the result and blocks the next result load, and so further requests.
// rst_n (async, active low) empties all queues; no clearing pass is needed.
`include "assert_macros.svh"

module three_level_priority_queue_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tlpq_pkg::IN_TDATA_W-1:0]    s_tdata,   // [31:0] data_in, [33:32] level,
                                                          // [39:34] zero
    input  logic                               s_tuser,   // [0] action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tlpq_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [31:0] data_out,
                                                          // [33:32] served_level, [39:34] zero
    output logic [1:0]                         m_tuser    // [1:0] status
);
    import tlpq_pkg::*;

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] out_data;
    logic [1:0]  out_served;

    tlpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tlpq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_tuser),
        .in_data    (s_tdata[31:0]),
        .in_level   (s_tdata[33:32]),
        .m_tready   (m_tready),
        .out_status (m_tuser),
        .out_data   (out_data),
        .out_served (out_served)
    );

    assign m_tvalid = stat.out_valid;
    assign m_tdata  = {6'd0, out_served, out_data};

    `ASSERT_CLK(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "early second request")
    `ASSERT_CLK(a_no_overwrite, cmd.result_load |-> (!m_tvalid || m_tready), "result overwritten")
    `ASSERT_CLK(a_fail_no_data, (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0), "fail data")
    `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "overlapping datapath commands")

endmodule

FILE: sv/tlpq_ctrl.sv
module tlpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               m_tready,
    input  tlpq_pkg::dp_stat_t stat,
    output tlpq_pkg::dp_cmd_t  cmd
);
    import tlpq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_free;

    assign out_free = !stat.out_valid || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd.item_load   = 1'b0;
        cmd.exec        = 1'b0;
        cmd.result_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // wait for the output register to drain
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/tlpq_datapath.sv
module tlpq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tlpq_pkg::dp_cmd_t   cmd,
    output tlpq_pkg::dp_stat_t  stat,
    input  logic                in_action,
    input  logic [31:0]         in_data,
    input  logic [1:0]          in_level,
    input  logic                m_tready,
    output tlpq_pkg::status_t   out_status,
    output logic [31:0]         out_data,
    output logic [1:0]          out_served
);
    import tlpq_pkg::*;

    // accepted item
    logic        action_reg;
    word_t       data_reg;
    logic [1:0]  level_reg;

    // queue state
    word_t             mem [NUM_LEVELS][DEPTH];
    logic [PTR_W-1:0]  head_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]  count_reg [NUM_LEVELS];

    // result staging
    status_t     res_status_reg;
    logic [1:0]  res_served_reg;
    logic        res_deq_reg;
    word_t       rd_data_reg;

    // output register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [31:0] out_data_reg;
    logic [1:0]  out_served_reg;

    logic [Q_W-1:0]   q_sel;
    logic             deq_found;
    logic             enq_ok;
    logic             deq_ok;
    status_t          status_c;
    logic [1:0]       served_c;
    logic [PTR_W-1:0] head_c;
    logic [CNT_W-1:0] count_c;
    logic [PTR_W-1:0] head_inc;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail_c;

    always_comb
    begin
        deq_found = 1'b1;
        priority if (count_reg[0] != '0)
            q_sel = Q_W'(0);
        else if (count_reg[1] != '0)
            q_sel = Q_W'(1);
        else if (count_reg[2] != '0)
            q_sel = Q_W'(2);
        else
        begin
            q_sel     = Q_W'(0);
            deq_found = 1'b0;
        end
        if (action_reg == ACT_ENQ)
        begin
            q_sel = (level_reg == 2'd0) ? Q_W'(0) : Q_W'(level_reg - 2'd1);
        end
    end

    assign head_c   = head_reg[q_sel];
    assign count_c  = count_reg[q_sel];
    assign head_inc = (head_c == PTR_W'(DEPTH - 1)) ? '0 : head_c + PTR_W'(1);
    assign tail_sum = SUM_W'(head_c) + SUM_W'(count_c);
    assign tail_c   = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(tail_sum);

    always_comb
    begin
        enq_ok   = 1'b0;
        deq_ok   = 1'b0;
        status_c = ST_OK;
        served_c = 2'd0;
        if (action_reg == ACT_ENQ)
        begin
            priority if (level_reg == 2'd0)
                status_c = ST_BADLEVEL;
            else if (count_c == CNT_W'(DEPTH))
                status_c = ST_FULL;
            else
            begin
                enq_ok   = 1'b1;
                served_c = level_reg;
            end
        end
        else
        begin
            if (!deq_found)
                status_c = ST_EMPTY;
            else
            begin
                deq_ok   = 1'b1;
                served_c = 2'(q_sel) + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            action_reg <= in_action;
            data_reg   <= DATA_WIDTH'($unsigned(in_data));
            level_reg  <= in_level;
        end
        if (cmd.exec)
        begin
            res_status_reg <= status_c;
            res_served_reg <= served_c;
            res_deq_reg    <= deq_ok;
        end
        if (cmd.result_load)
        begin
            out_status_reg <= res_status_reg;
            out_served_reg <= res_served_reg;
            out_data_reg   <= res_deq_reg ? to_out32(rd_data_reg) : 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && enq_ok)
        begin
            mem[q_sel][tail_c] <= data_reg;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= mem[q_sel][head_c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec && enq_ok)
            begin
                count_reg[q_sel] <= count_c + CNT_W'(1);
            end
            else if (cmd.exec && deq_ok)
            begin
                count_reg[q_sel] <= count_c - CNT_W'(1);
                head_reg[q_sel]  <= head_inc;
            end
            if (cmd.result_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_data       = out_data_reg;
    assign out_served     = out_served_reg;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import tlpq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 450;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [1:0] NO_LEVEL = 2'd0;

    typedef struct {
        status_t     status;
        logic [31:0] word;
        logic [1:0]  lvl;
    } queue_result_t;

    // Shadow copy of the three level FIFOs plus the results still owed by the block.
    class queue_result_checker;
        word_t         shadow_store [NUM_LEVELS][DEPTH];
        int unsigned   shadow_head  [NUM_LEVELS];
        int unsigned   shadow_count [NUM_LEVELS];
        queue_result_t pending_results[$];
        int            mismatches;

        function new();
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                shadow_head[i]  = 0;
                shadow_count[i] = 0;
            end
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Apply one accepted request to the shadow queues and queue its result.
        function void apply_request(logic act, logic [31:0] d, logic [1:0] lv);
            queue_result_t          r;
            int                     q;
            logic signed [DATA_WIDTH-1:0] sw;
            r.status = ST_OK;
            r.word   = '0;
            r.lvl    = NO_LEVEL;
            if (act == ACT_ENQ)
            begin
                if (lv == NO_LEVEL)
                    r.status = ST_BADLEVEL;
                else
                begin
                    q = lv - 1;
                    if (shadow_count[q] >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        shadow_store[q][(shadow_head[q] + shadow_count[q]) % DEPTH] = word_t'(d);
                        shadow_count[q]++;
                        r.lvl = lv;
                    end
                end
            end
            else
            begin
                q = 0;
                while (q < NUM_LEVELS && shadow_count[q] == 0)
                    q++;
                if (q == NUM_LEVELS)
                    r.status = ST_EMPTY;
                else
                begin
                    sw              = shadow_store[q][shadow_head[q]];
                    r.word          = 32'(sw);
                    shadow_head[q]  = (shadow_head[q] + 1) % DEPTH;
                    shadow_count[q]--;
                    r.lvl           = 2'(q + 1);
                end
            end
            pending_results.push_back(r);
        endfunction

        task check_result(status_t st, logic [31:0] d, logic [1:0] lv);
            queue_result_t e;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: status=%0d data=%h level=%0d",
                                          st, d, lv));
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
            if (d !== e.word)
                report_mismatch($sformatf("data_out %h, expected %h", d, e.word));
            if (lv !== e.lvl)
                report_mismatch($sformatf("served_level %0d, expected %0d", lv, e.lvl));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [31:0] data_in, [33:32] level, [39:34] zero
    logic        s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] data_out, [33:32] served_level, [39:34] zero
    logic [1:0]  m_tuser;   // [1:0] status

    queue_result_checker results = new();

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    bit          hold_request = 1'b0;
    int unsigned cycle_count  = 0;

    three_level_priority_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offer one request, with random idle cycles first, and wait for the transaction.
    task automatic send_item(logic act, logic [31:0] d, logic [1:0] lv);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, lv, d};
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        results.apply_request(act, d, lv);
    endtask

    // Result side: checks each transaction, stalls at random, long hold on request.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                results.check_result(status_t'(m_tuser), m_tdata[31:0], m_tdata[33:32]);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin : stimulus
        logic        act;
        logic [1:0]  lv;
        logic [31:0] word;
        int          seg_left;
        int          enq_pct;
        int          focus;
        int          sent;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_ENQ;
        seg_left = 0;
        enq_pct  = 50;
        focus    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dequeue, bad level, field extremes, fill level 1 to full,
        // priority order on dequeue, tail wrap.
        send_item(ACT_DEQ, 32'hDEAD_BEEF, 2'd3);
        send_item(ACT_ENQ, 32'hFFFF_FFFF, NO_LEVEL);
        send_item(ACT_ENQ, 32'h8000_0000, 2'd3);
        send_item(ACT_ENQ, 32'h7FFF_FFFF, 2'd2);
        send_item(ACT_ENQ, 32'hFFFF_FFFF, 2'd1);
        send_item(ACT_ENQ, 32'h0000_0000, 2'd1);
        for (int i = 2; i < DEPTH; i++)
            send_item(ACT_ENQ, (32'h0101_0101 * i) ^ 32'hA5A5_A5A5, 2'd1);
        send_item(ACT_ENQ, 32'h1234_5678, 2'd1);
        send_item(ACT_DEQ, 32'h0000_0000, NO_LEVEL);
        send_item(ACT_ENQ, 32'h5A5A_5A5A, 2'd1);
        send_item(ACT_DEQ, 32'hFFFF_FFFF, 2'd2);

        // Random: segments of varying enqueue/dequeue mix drive levels to full and empty.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    hold_request = 1'b1;
                end
                1:
                begin
                    tx_idle_pct  = 51;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 51;
                end
                default:
                begin
                    tx_idle_pct  = 22;
                    rx_stall_pct = 22;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(20, 80);
                    focus    = $urandom_range(0, 3);
                    case ($urandom_range(3))
                        0:       enq_pct = 15;
                        1:       enq_pct = 50;
                        2:       enq_pct = 85;
                        default: enq_pct = 97;
                    endcase
                end
                if ($urandom_range(99) < enq_pct)
                begin
                    act = ACT_ENQ;
                    if ($urandom_range(99) < 5)
                        lv = NO_LEVEL;
                    else if (focus != 0 && $urandom_range(99) < 70)
                        lv = 2'(focus);
                    else
                        lv = 2'($urandom_range(1, 3));
                end
                else
                begin
                    act = ACT_DEQ;
                    lv  = 2'($urandom_range(0, 3));
                end
                case ($urandom_range(9))
                    0:       word = 32'h8000_0000;
                    1:       word = 32'h7FFF_FFFF;
                    2:       word = 32'hFFFF_FFFF;
                    3:       word = 32'h0000_0000;
                    default: word = $urandom;
                endcase
                send_item(act, word, lv);
                sent++;
                seg_left--;
            end
        end

        s_tvalid     <= 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        while (results.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (results.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
